// ===== rtl/core/ier_pkg.sv =====
// ----------------------------------------------------------------------------
// ier_pkg
// Shared constants, types and helpers for the ICMP echo request builder.
// ----------------------------------------------------------------------------
package ier_pkg;

  // Body capacity of one packet and the fixed header length
  localparam int MAX_BODY_BYTES = 56;
  localparam int HDR_BYTES      = 8;

  // Two body banks: one fills while the other drains
  localparam int NUM_BANKS = 2;
  localparam int RAM_DEPTH = NUM_BANKS * MAX_BODY_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // Body byte count, packet byte index
  localparam int CNT_W = $clog2(MAX_BODY_BYTES + 1);
  localparam int IDX_W = $clog2(HDR_BYTES + MAX_BODY_BYTES);

  // Weighted body sum and the header-inclusive checksum accumulator
  localparam int SUM_W = $clog2(((MAX_BODY_BYTES + 1) / 2) * 65535 + 1);
  localparam int CK_W  = SUM_W + 2;

  // Descriptor queue and output buffer depths (powers of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int OFIFO_DEPTH = 4;

  // Echo request header codes
  localparam logic [7:0] ECHO_TYPE = 8'd8;
  localparam logic [7:0] ECHO_CODE = 8'd0;

  // One finished packet, handed from the front to the back
  typedef struct packed {
    logic               bank;
    logic [CNT_W-1:0]   count;
    logic [SUM_W-1:0]   sum;
    logic [15:0]        ident;
    logic [15:0]        seq;
    logic               ovf;
  } ier_desc_t;

  // Bank release from the back to the front
  typedef struct packed {
    logic valid;
    logic bank;
  } ier_rel_t;

  // Body buffer write
  typedef struct packed {
    logic              valid;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ier_wr_t;

  // Map bank and body position to a buffer address
  function automatic logic [RAM_AW-1:0] ram_addr(input logic bank,
                                                  input logic [CNT_W-1:0] idx);
    logic [RAM_AW-1:0] base;
    base = bank ? RAM_AW'(MAX_BODY_BYTES) : '0;
    return base + RAM_AW'(idx);
  endfunction

endpackage

// ===== rtl/core/ier_if.sv =====
// ----------------------------------------------------------------------------
// ier_in_if / ier_out_if
// Valid/ready channels for body items and serialized packet bytes.
// ----------------------------------------------------------------------------
interface ier_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ident;
  logic [15:0] seq_num;
  logic [7:0]  body_byte;
  logic        byte_present;
  logic        body_last;

  modport source(output valid, ident, seq_num, body_byte, byte_present, body_last,
                 input ready);
  modport sink(input valid, ident, seq_num, body_byte, byte_present, body_last,
               output ready);
endinterface

interface ier_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_last;
  logic       body_overflow;

  modport source(output valid, packet_byte, packet_last, body_overflow,
                 input ready);
  modport sink(input valid, packet_byte, packet_last, body_overflow,
               output ready);
endinterface

// ===== rtl/core/ier_ram.sv =====
// ----------------------------------------------------------------------------
// ier_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ier_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ier_queue.sv =====
// ----------------------------------------------------------------------------
// ier_queue
// Short descriptor FIFO between the accumulating front and the emitting back.
// ----------------------------------------------------------------------------
module ier_queue import ier_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ier_desc_t din,
  input  logic      pop,
  output ier_desc_t dout,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  ier_desc_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [CNT_QW-1:0]  cnt_r;

  assign full  = (cnt_r == CNT_QW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_QW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_QW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ier_front.sv =====
// ----------------------------------------------------------------------------
// ier_front
// Accepts body items, samples the header fields, buffers body bytes into the
// current bank and accumulates the weighted body sum.
// ----------------------------------------------------------------------------
module ier_front import ier_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ier_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      desc_push,
  output ier_desc_t desc,
  output ier_wr_t   wr,
  input  ier_rel_t  rel
);

  logic               mid_r;
  logic               bank_r;
  logic [1:0]         busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, base_cnt;
  logic [SUM_W-1:0]   sum_r, sum_nxt, base_sum, addend;
  logic               ovf_r, ovf_nxt;
  logic [15:0]        ident_r, ident_nxt;
  logic [15:0]        seq_r, seq_nxt;
  logic               accept, first, room, take;

  // Hold off a new packet until its bank has been drained
  assign in_ch.ready = !q_full && (mid_r || !busy_r[bank_r]);
  assign accept      = in_ch.valid && in_ch.ready;
  assign first       = !mid_r;

  // Start a fresh packet context on the first transaction
  always_comb begin
    base_cnt  = first ? '0 : cnt_r;
    base_sum  = first ? '0 : sum_r;
    ident_nxt = first ? in_ch.ident : ident_r;
    seq_nxt   = first ? in_ch.seq_num : seq_r;
    room      = (base_cnt < CNT_W'(MAX_BODY_BYTES));
    take      = in_ch.byte_present && room;
    // Even positions carry the high byte of a 16-bit word
    addend    = base_cnt[0] ? SUM_W'(in_ch.body_byte)
                            : SUM_W'({in_ch.body_byte, 8'h00});
    cnt_nxt   = take ? base_cnt + CNT_W'(1) : base_cnt;
    sum_nxt   = take ? base_sum + addend : base_sum;
    ovf_nxt   = (first ? 1'b0 : ovf_r) | (in_ch.byte_present & !room);
  end

  // Buffer write for a kept byte
  always_comb begin
    wr.valid = accept && take;
    wr.addr  = ram_addr(bank_r, base_cnt);
    wr.data  = in_ch.body_byte;
  end

  // Hand the finished packet to the back
  always_comb begin
    desc_push   = accept && in_ch.body_last;
    desc.bank   = bank_r;
    desc.count  = cnt_nxt;
    desc.sum    = sum_nxt;
    desc.ident  = ident_nxt;
    desc.seq    = seq_nxt;
    desc.ovf    = ovf_nxt;
  end

  // Claim a bank on the first transaction, free it on release
  always_comb begin
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept && first) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  // Packet context registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r   <= 1'b0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
      ident_r <= '0;
      seq_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (accept) begin
        mid_r   <= !in_ch.body_last;
        cnt_r   <= cnt_nxt;
        sum_r   <= sum_nxt;
        ovf_r   <= ovf_nxt;
        ident_r <= ident_nxt;
        seq_r   <= seq_nxt;
        if (in_ch.body_last) begin
          bank_r <= ~bank_r;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ier_back.sv =====
// ----------------------------------------------------------------------------
// ier_back
// Folds the checksum of a queued packet and serializes header and body bytes
// through a registered buffer read into a small output FIFO.
// ----------------------------------------------------------------------------
module ier_back import ier_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ier_desc_t         q_dout,
  output logic              q_pop,
  output logic [RAM_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output ier_rel_t          rel,
  ier_out_if.source         out_ch
);

  localparam int OP_W = $clog2(OFIFO_DEPTH);
  localparam int OC_W = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_FOLD_A,
    ST_FOLD_B,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } obyte_t;

  state_t            state_r;
  ier_desc_t         d_r;
  logic [CK_W-1:0]   ck_r;
  logic [IDX_W-1:0]  idx_r;
  logic              s2_valid_r, s2_body_r, s2_last_r, s2_ovf_r;
  logic [7:0]        s2_hdr_r;

  obyte_t            ofifo_r [OFIFO_DEPTH];
  logic [OP_W-1:0]   wp_r, rp_r;
  logic [OC_W-1:0]   ocnt_r;
  obyte_t            push_entry;

  logic [15:0]       csum;
  logic [IDX_W:0]    last_idx;
  logic              is_last, is_body, issue, opop;
  logic [CNT_W-1:0]  body_idx;
  logic [7:0]        hdr_byte;

  // Take the next descriptor when idle
  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // Byte selection for the current packet index
  always_comb begin
    csum     = ~ck_r[15:0];
    last_idx = (IDX_W+1)'(HDR_BYTES - 1) + (IDX_W+1)'(d_r.count);
    is_last  = ({1'b0, idx_r} == last_idx);
    is_body  = (idx_r >= IDX_W'(HDR_BYTES));
    body_idx = CNT_W'(idx_r - IDX_W'(HDR_BYTES));
    rd_addr  = ram_addr(d_r.bank, body_idx);
    unique case (idx_r[2:0])
      3'd0:    hdr_byte = ECHO_TYPE;
      3'd1:    hdr_byte = ECHO_CODE;
      3'd2:    hdr_byte = csum[15:8];
      3'd3:    hdr_byte = csum[7:0];
      3'd4:    hdr_byte = d_r.ident[15:8];
      3'd5:    hdr_byte = d_r.ident[7:0];
      3'd6:    hdr_byte = d_r.seq[15:8];
      default: hdr_byte = d_r.seq[7:0];
    endcase
  end

  // Issue only with room for everything in flight
  assign issue = (state_r == ST_EMIT) &&
                 ((OC_W+1)'(ocnt_r) + (OC_W+1)'(s2_valid_r) < (OC_W+1)'(OFIFO_DEPTH));

  // Free the bank once its last byte has been read
  assign rel.valid = issue && is_last;
  assign rel.bank  = d_r.bank;

  // Sequencer and read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s2_valid_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      s2_valid_r <= issue;
      if (issue) begin
        s2_body_r <= is_body;
        s2_hdr_r  <= hdr_byte;
        s2_last_r <= is_last;
        s2_ovf_r  <= d_r.ovf;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            d_r     <= q_dout;
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          ck_r    <= CK_W'(d_r.sum) + CK_W'({ECHO_TYPE, ECHO_CODE}) +
                     CK_W'(d_r.ident) + CK_W'(d_r.seq);
          state_r <= ST_FOLD_A;
        end
        ST_FOLD_A: begin
          ck_r    <= CK_W'(ck_r[15:0]) + CK_W'(ck_r[CK_W-1:16]);
          state_r <= ST_FOLD_B;
        end
        ST_FOLD_B: begin
          ck_r    <= CK_W'(ck_r[15:0]) + CK_W'(ck_r[CK_W-1:16]);
          idx_r   <= '0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (issue) begin
            idx_r <= idx_r + IDX_W'(1);
            if (is_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output FIFO: merge buffer data with header bytes
  always_comb begin
    push_entry.data = s2_body_r ? rd_data : s2_hdr_r;
    push_entry.last = s2_last_r;
    push_entry.ovf  = s2_ovf_r;
  end

  assign opop                 = out_ch.valid && out_ch.ready;
  assign out_ch.valid         = (ocnt_r != '0);
  assign out_ch.packet_byte   = ofifo_r[rp_r].data;
  assign out_ch.packet_last   = ofifo_r[rp_r].last;
  assign out_ch.body_overflow = ofifo_r[rp_r].ovf;

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      ofifo_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      ocnt_r <= '0;
    end else begin
      if (s2_valid_r) begin
        wp_r <= wp_r + OP_W'(1);
      end
      if (opop) begin
        rp_r <= rp_r + OP_W'(1);
      end
      if (s2_valid_r && !opop) begin
        ocnt_r <= ocnt_r + OC_W'(1);
      end else if (opop && !s2_valid_r) begin
        ocnt_r <= ocnt_r - OC_W'(1);
      end
    end
  end

`ifndef SYNTH
  // Output FIFO never exceeds its depth
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OC_W'(OFIFO_DEPTH))
    else $error("output FIFO occupancy out of range");

  // A read-stage byte never lands in a full FIFO without a pop
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && ocnt_r == OC_W'(OFIFO_DEPTH)) |-> opop)
    else $error("output FIFO overfilled");

  // Releasing a bank ends the packet
  a_rel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rel.valid |=> state_r == ST_IDLE)
    else $error("bank released mid-packet");

  // Taking a descriptor starts the checksum
  a_pop_sum: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_SUM)
    else $error("descriptor pop without checksum start");
`endif

endmodule

// ===== rtl/core/icmp_echo_request_builder.sv =====
// ----------------------------------------------------------------------------
// icmp_echo_request_builder
// Builds an ICMP echo request with its internet checksum from body bytes.
// ----------------------------------------------------------------------------
// Body items are taken at one per cycle while a packet is open; each kept
// byte goes into one of two 56-byte buffer banks and into the running sum.
// On the last item the packet is queued to the back, which takes the
// descriptor, adds the header words and folds the checksum twice, then
// emits the 8 header bytes and the body through a registered buffer read
// and a four-entry output FIFO, one byte per cycle while that FIFO has room.
// While one bank drains, the next packet fills the other; the first item of
// a packet waits only when both banks still hold packets not yet emitted.
// Body bytes past 56 are dropped and flag body_overflow on every byte of
// that packet.
module icmp_echo_request_builder import ier_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ier_in_if.sink     in_ch,
  ier_out_if.source  out_ch
);

  logic              desc_push, q_pop, q_full, q_empty;
  ier_desc_t         desc, q_dout;
  ier_wr_t           wr;
  ier_rel_t          rel;
  logic [RAM_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  // Accept and accumulate
  ier_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .desc_push (desc_push),
    .desc      (desc),
    .wr        (wr),
    .rel       (rel)
  );

  // Packet descriptors between front and back
  ier_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .din   (desc),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // Two-bank body buffer
  ier_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.valid),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Checksum fold and serialize
  ier_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rel     (rel),
    .out_ch  (out_ch)
  );

endmodule

// ===== test/icmp_echo_request_builder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icmp_echo_request_builder_tb
// Sends echo request bodies through the builder and checks every packet byte.
// The expected bytes come from a model of the header, the folded internet
// checksum and the stored body. A short table of hand-picked items runs
// first. Random packets follow, with stalls on both sides, one long
// receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module icmp_echo_request_builder_tb;
  import ier_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RUN_LIMIT    = 500000;
  localparam int RAND_ITEMS   = 70;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_SHOWN    = 40;
  localparam int DIR_ROWS     = 18;

  // One body item; typed rows carry a checksum worked out by hand
  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] seq;
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        typed;
    logic [15:0] csum;
  } body_item_t;

  // One serialized packet byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } pkt_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  ier_in_if  in_ch();
  ier_out_if out_ch();

  icmp_echo_request_builder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Directed items: header extremes, carries, empty items and short bodies
  body_item_t dir_table [DIR_ROWS] = '{
    //  ident      seq        data   pres  last  typed csum
    '{16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, 16'hF7FF}, // empty body after reset
    '{16'hFFFF, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b1, 16'hF7FF}, // all-ones header words
    '{16'hF7FF, 16'h0000, 8'hFF, 1'b0, 1'b1, 1'b1, 16'h0000}, // sum is all ones
    '{16'h0000, 16'hF800, 8'h00, 1'b0, 1'b1, 1'b1, 16'hFFFE}, // end-around carry
    '{16'h1234, 16'hABCD, 8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000}, // no byte, ident ignored
    '{16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b0, 16'h0000},
    '{16'h8000, 16'h0001, 8'hAA, 1'b0, 1'b0, 1'b0, 16'h0000}, // opening item without byte
    '{16'h0000, 16'h0000, 8'h80, 1'b1, 1'b1, 1'b0, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000}, // carries on every word
    '{16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000},
    '{16'hAAAA, 16'h5555, 8'h55, 1'b1, 1'b1, 1'b0, 16'h0000}, // single byte
    '{16'h5555, 16'hAAAA, 8'h01, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 16'h0000, 8'h02, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 16'h0000, 8'h04, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 16'h0000, 8'h08, 1'b1, 1'b1, 1'b0, 16'h0000},
    '{16'h00FF, 16'hFF00, 8'h7F, 1'b1, 1'b1, 1'b0, 16'h0000}
  };

  // Model state of the packet being collected
  logic [7:0]  body_mem [MAX_BODY_BYTES];
  int          body_len;
  logic [23:0] wsum;
  logic [15:0] held_id;
  logic [15:0] held_sq;
  bit          in_packet;
  bit          overflowed;

  pkt_byte_t   built_bytes[$];
  pkt_byte_t   pending_bytes[$];

  bit hold_request;
  bit quiet_tail;
  int error_count;
  int items_sent;
  int bytes_checked;
  int packets_built;
  int empty_packets;
  int overflow_packets;

  initial begin
    body_len = 0;
    wsum = '0;
    held_id = '0;
    held_sq = '0;
    in_packet = 1'b0;
    overflowed = 1'b0;
    hold_request = 1'b0;
    quiet_tail = 1'b0;
    error_count = 0;
    items_sent = 0;
    bytes_checked = 0;
    packets_built = 0;
    empty_packets = 0;
    overflow_packets = 0;
  end

  // Print one line per mismatch (up to a cap) and count them all
  task automatic flag_mismatch(input string msg);
    if (error_count < MAX_SHOWN)
      $display("ERROR at packet byte %0d: %s", bytes_checked, msg);
    error_count++;
  endtask

  function automatic void add_byte(input logic [7:0] d, input logic l);
    pkt_byte_t b;
    b.data = d;
    b.last = l;
    b.ovf = overflowed;
    built_bytes.push_back(b);
  endfunction

  // Eight header bytes in network order
  function automatic void put_header(input logic [15:0] ck, input logic [15:0] id,
                                     input logic [15:0] sq, input logic sq_last);
    add_byte(ECHO_TYPE, 1'b0);
    add_byte(ECHO_CODE, 1'b0);
    add_byte(ck[15:8], 1'b0);
    add_byte(ck[7:0], 1'b0);
    add_byte(id[15:8], 1'b0);
    add_byte(id[7:0], 1'b0);
    add_byte(sq[15:8], 1'b0);
    add_byte(sq[7:0], sq_last);
  endfunction

  // Take one accepted body item; on the closing item build the whole packet
  function automatic void absorb_item(input body_item_t it);
    logic [31:0] s;
    logic [15:0] ck;
    built_bytes.delete();
    if (!in_packet) begin
      held_id = it.ident;
      held_sq = it.seq;
      body_len = 0;
      wsum = '0;
      overflowed = 1'b0;
    end
    // Keep the byte while there is room; even positions weigh as high byte
    if (it.present) begin
      if (body_len < MAX_BODY_BYTES) begin
        body_mem[body_len] = it.data;
        wsum = wsum + ((body_len % 2 == 0) ? 24'({it.data, 8'h00}) : 24'(it.data));
        body_len++;
      end else begin
        overflowed = 1'b1;
      end
    end
    if (!it.last) begin
      in_packet = 1'b1;
      return;
    end
    in_packet = 1'b0;
    // Fold carries until none remain, then invert
    s = 32'(wsum) + 32'({ECHO_TYPE, ECHO_CODE}) + 32'(held_id) + 32'(held_sq);
    while (s[31:16] != 16'h0000)
      s = 32'(s[15:0]) + 32'(s[31:16]);
    ck = ~s[15:0];
    put_header(ck, held_id, held_sq, body_len == 0);
    for (int i = 0; i < body_len; i++)
      add_byte(body_mem[i], i == body_len - 1);
    packets_built++;
    if (body_len == 0)
      empty_packets++;
    if (overflowed)
      overflow_packets++;
  endfunction

  // Offer one item, hold it until the transaction completes, then predict
  task automatic offer_item(input body_item_t it);
    in_ch.valid        <= 1'b1;
    in_ch.ident        <= it.ident;
    in_ch.seq_num      <= it.seq;
    in_ch.body_byte    <= it.data;
    in_ch.byte_present <= it.present;
    in_ch.body_last    <= it.last;
    do @(posedge clk); while (!in_ch.ready);
    absorb_item(it);
    if (it.typed) begin
      built_bytes.delete();
      put_header(it.csum, it.ident, it.seq, 1'b1);
    end
    foreach (built_bytes[i])
      pending_bytes.push_back(built_bytes[i]);
    items_sent++;
  endtask

  // Sometimes drop valid for a short burst
  task automatic sender_gap();
    int n;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_packet(input int n_items, input bit all_present);
    body_item_t it;
    for (int k = 0; k < n_items; k++) begin
      it.ident   = 16'($urandom_range(0, 65535));
      it.seq     = 16'($urandom_range(0, 65535));
      it.data    = 8'($urandom_range(0, 255));
      it.present = all_present || ($urandom_range(0, 9) != 0);
      it.last    = (k == n_items - 1);
      it.typed   = 1'b0;
      it.csum    = '0;
      offer_item(it);
      sender_gap();
    end
  endtask

  // Compare one received byte against the oldest expectation
  task automatic check_packet_byte(input logic [7:0] d, input logic l, input logic o);
    pkt_byte_t want;
    if (pending_bytes.size() == 0) begin
      flag_mismatch($sformatf("unexpected byte %02h (last %b, overflow %b)", d, l, o));
    end else begin
      want = pending_bytes.pop_front();
      if (d !== want.data)
        flag_mismatch($sformatf("packet_byte %02h, expected %02h", d, want.data));
      if (l !== want.last)
        flag_mismatch($sformatf("packet_last %b, expected %b", l, want.last));
      if (o !== want.ovf)
        flag_mismatch($sformatf("body_overflow %b, expected %b", o, want.ovf));
    end
    bytes_checked++;
  endtask

  // Receiver: check each transaction, stall in bursts or on a long hold request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        check_packet_byte(out_ch.packet_byte, out_ch.packet_last, out_ch.body_overflow);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (hold_request) begin
          hold_request = 1'b0;
          stall_left = LONG_HOLD;
        end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 13);
        end
        if (stall_left > 0) begin
          out_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Cycle counter: end a hung run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d bytes still expected",
             RUN_LIMIT, pending_bytes.size());
    $display("icmp_echo_request_builder: mismatch");
    $finish;
  end

  initial begin : stimulus
    int rand_items;
    int pkt;
    int n_items;
    bit all_present;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.ident        <= '0;
    in_ch.seq_num      <= '0;
    in_ch.body_byte    <= '0;
    in_ch.byte_present <= 1'b0;
    in_ch.body_last    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_table[i]) begin
      offer_item(dir_table[i]);
      sender_gap();
    end

    // Random packets: mostly short, one that overflows the body buffer
    rand_items = 0;
    pkt = 0;
    while (pkt < 7 || rand_items < RAND_ITEMS) begin
      quiet_tail = (pkt >= 5);
      // Hold the receiver off while packets keep coming
      if (pkt == 1)
        hold_request = 1'b1;
      // Pause until every expected byte has come out
      if (pkt == 4) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_bytes.size() != 0);
      end
      all_present = 1'b0;
      if (pkt == 4) begin
        n_items = MAX_BODY_BYTES + 1;
        all_present = 1'b1;
      end else begin
        n_items = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      end
      rand_items += n_items;
      send_packet(n_items, all_present);
      pkt++;
    end
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray bytes
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d body items as %0d echo requests (%0d empty bodies, %0d overflowed).",
             items_sent, packets_built, empty_packets, overflow_packets);
    $display("Checked %0d packet bytes under random stalls, a long receiver hold and a drain.",
             bytes_checked);
    if (error_count == 0)
      $display("icmp_echo_request_builder: match");
    else
      $display("icmp_echo_request_builder: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ier_pkg.sv
rtl/core/ier_if.sv
rtl/core/ier_ram.sv
rtl/core/ier_queue.sv
rtl/core/ier_front.sv
rtl/core/ier_back.sv
rtl/core/icmp_echo_request_builder.sv
test/icmp_echo_request_builder_tb.sv
